// ===== rtl/core/hsd_pkg.sv =====
`timescale 1ns / 1ps

package hsd_pkg;

  // Node store
  localparam int unsigned NodeDepth = 512;
  localparam int unsigned NodeAw    = $clog2(NodeDepth);
  localparam int unsigned NodeCw    = NodeAw + 1;

  // Stream format
  localparam int unsigned SizeBits  = 20;
  localparam int unsigned RepBits   = 20;
  localparam logic [7:0]  SigByte   = 8'h77;

  // Parse phases
  localparam logic [3:0] PH_SIG   = 4'd0;
  localparam logic [3:0] PH_FLAT  = 4'd1;
  localparam logic [3:0] PH_FSIZE = 4'd2;
  localparam logic [3:0] PH_FRES  = 4'd3;
  localparam logic [3:0] PH_FDATA = 4'd4;
  localparam logic [3:0] PH_COUNT = 4'd5;
  localparam logic [3:0] PH_ELEN  = 4'd6;
  localparam logic [3:0] PH_ECODE = 4'd7;
  localparam logic [3:0] PH_EBYTE = 4'd8;
  localparam logic [3:0] PH_CSIZE = 4'd9;
  localparam logic [3:0] PH_WALK  = 4'd10;
  localparam logic [3:0] PH_DONE  = 4'd11;
  localparam logic [3:0] PH_HALT  = 4'd12;

  // Result status
  localparam logic [1:0] ST_DATA    = 2'd0;
  localparam logic [1:0] ST_BAD_SIG = 2'd1;
  localparam logic [1:0] ST_CORRUPT = 2'd2;

endpackage

// ===== rtl/core/huffman_stream_decoder.sv =====
`timescale 1ns / 1ps

// Huffman stream decoder. Takes one compressed byte per input item, bit 7 first, and
// produces zero to eight result items per byte (last marks the final one of that byte).
// An item is accepted in the idle state, then its bits are stepped through one by one and
// the held result, if any, is handed over as the last; no new item is taken until then. A
// header or flat bit is a single step (the last size bit of a coded stream also tests the
// root), a code-definition bit reads the child slot (and clears and links a new node when
// one is allocated) and a decode bit follows the child and tests for a leaf, all through
// the node store (one registered read per cycle). The output side can stall these steps.
// After reset the root node is written once before the first item is taken.
module huffman_stream_decoder
  import hsd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          stream_byte_i,
  input  logic                stream_start_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          symbol_o,
  output logic [RepBits-1:0]  repeat_count_o,
  output logic [1:0]          status_o,
  output logic                stream_done_o,
  output logic                last_o
);

  // Sequencer states
  localparam logic [2:0] C_INIT  = 3'd0; // write the root after reset
  localparam logic [2:0] C_IDLE  = 3'd1; // wait for an item
  localparam logic [2:0] C_BIT   = 3'd2; // take the next bit, or flush at the end
  localparam logic [2:0] C_CNODE = 3'd3; // code definition: look at the child slot
  localparam logic [2:0] C_CINIT = 3'd4; // code definition: clear the new node
  localparam logic [2:0] C_CLINK = 3'd5; // code definition: link the new node
  localparam logic [2:0] C_WNODE = 3'd6; // decode: follow the child
  localparam logic [2:0] C_WLEAF = 3'd7; // decode: test for a leaf (also root test)

  // Node store: left/right child (0 means none) and leaf byte
  logic [NodeAw-1:0] lm_q [NodeDepth];
  logic [NodeAw-1:0] rm_q [NodeDepth];
  logic [7:0]        bm_q [NodeDepth];
  logic [NodeAw-1:0] l_rd_q, r_rd_q;
  logic [7:0]        b_rd_q;

  logic              rd_en;
  logic [NodeAw-1:0] raddr, waddr, wd_c;
  logic [7:0]        wd_b;
  logic              we_l, we_r, we_b;

  // Control
  logic [2:0]          ctl_q, ctl_d;
  logic [3:0]          phase_q, phase_d;
  logic [4:0]          bl_q, bl_d;
  logic [SizeBits-1:0] acc_q, acc_d;
  logic [8:0]          ent_q, ent_d;
  logic [NodeCw-1:0]   used_q, used_d;
  logic [NodeAw-1:0]   cur_q, cur_d;
  logic [SizeBits-1:0] rem_q, rem_d;
  logic [7:0]          sh_q, sh_d;
  logic [3:0]          cnt_q, cnt_d;
  logic                root_tst_q, root_tst_d;

  // Pending result (held back until we know whether it is the last of the item)
  logic                pend_v_q;
  logic [7:0]          pend_sym_q;
  logic [RepBits-1:0]  pend_rep_q;
  logic [1:0]          pend_st_q;
  logic                pend_done_q;

  // Output register
  logic                out_v_q;
  logic [7:0]          out_sym_q;
  logic [RepBits-1:0]  out_rep_q;
  logic [1:0]          out_st_q;
  logic                out_done_q, out_last_q;

  logic                emit, out_push, out_last, pend_clr, consume;
  logic [7:0]          e_sym;
  logic [RepBits-1:0]  e_rep;
  logic [1:0]          e_st;
  logic                e_done;

  logic                bit_v, out_free, can_emit;
  logic [SizeBits-1:0] acc_n;
  logic [4:0]          bl_n;
  logic [NodeAw-1:0]   slot;
  logic                accept;

  assign bit_v    = sh_q[7];
  assign out_free = !out_v_q || out_ready_i;
  assign can_emit = !pend_v_q || out_free;
  assign acc_n    = {acc_q[SizeBits-2:0], bit_v};
  assign bl_n     = bl_q - 5'd1;
  assign slot     = bit_v ? r_rd_q : l_rd_q;

  assign in_ready_o = (ctl_q == C_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    ctl_d      = ctl_q;
    phase_d    = phase_q;
    bl_d       = bl_q;
    acc_d      = acc_q;
    ent_d      = ent_q;
    used_d     = used_q;
    cur_d      = cur_q;
    rem_d      = rem_q;
    sh_d       = sh_q;
    cnt_d      = cnt_q;
    root_tst_d = root_tst_q;
    rd_en      = 1'b0;
    raddr      = cur_q;
    waddr      = cur_q;
    wd_c       = '0;
    wd_b       = '0;
    we_l       = 1'b0;
    we_r       = 1'b0;
    we_b       = 1'b0;
    emit       = 1'b0;
    e_sym      = '0;
    e_rep      = '0;
    e_st       = ST_DATA;
    e_done     = 1'b0;
    out_push   = 1'b0;
    out_last   = 1'b0;
    pend_clr   = 1'b0;
    consume    = 1'b0;

    unique case (ctl_q)
      C_INIT: begin
        waddr = '0;
        we_l  = 1'b1;
        we_r  = 1'b1;
        we_b  = 1'b1;
        ctl_d = C_IDLE;
      end

      C_IDLE: begin
        if (accept) begin
          sh_d  = stream_byte_i;
          cnt_d = 4'd8;
          ctl_d = C_BIT;
          if (stream_start_i) begin
            // new stream: drop the tree and restart the parser
            waddr   = '0;
            we_l    = 1'b1;
            we_r    = 1'b1;
            we_b    = 1'b1;
            used_d  = NodeCw'(1);
            cur_d   = '0;
            ent_d   = '0;
            rem_d   = '0;
            phase_d = PH_SIG;
            bl_d    = 5'd8;
            acc_d   = '0;
          end
        end
      end

      C_BIT: begin
        if (cnt_q == 4'd0) begin
          // end of item: hand over the held result as the last one
          if (!pend_v_q) begin
            ctl_d = C_IDLE;
          end else if (out_free) begin
            out_push = 1'b1;
            out_last = 1'b1;
            pend_clr = 1'b1;
            ctl_d    = C_IDLE;
          end
        end else if (can_emit) begin
          unique case (phase_q)
            PH_DONE, PH_HALT: consume = 1'b1;
            PH_WALK: begin
              rd_en = 1'b1;
              ctl_d = C_WNODE;
            end
            PH_ECODE: begin
              rd_en = 1'b1;
              ctl_d = C_CNODE;
            end
            default: begin
              consume = 1'b1;
              acc_d   = acc_n;
              bl_d    = bl_n;
              if (bl_n == 5'd0) begin
                acc_d = '0;
                priority case (phase_q)
                  PH_SIG: begin
                    if (acc_n[7:0] != SigByte) begin
                      emit    = 1'b1;
                      e_st    = ST_BAD_SIG;
                      phase_d = PH_HALT;
                    end else begin
                      phase_d = PH_FLAT;
                      bl_d    = 5'd1;
                    end
                  end
                  PH_FLAT: begin
                    phase_d = bit_v ? PH_FSIZE : PH_COUNT;
                    bl_d    = bit_v ? 5'(SizeBits) : 5'd9;
                  end
                  PH_FSIZE: begin
                    rem_d   = acc_n;
                    phase_d = PH_FRES;
                    bl_d    = 5'd3;
                  end
                  PH_FRES: begin
                    if (rem_q == '0) begin
                      emit    = 1'b1;
                      e_done  = 1'b1;
                      phase_d = PH_DONE;
                    end else begin
                      phase_d = PH_FDATA;
                      bl_d    = 5'd8;
                    end
                  end
                  PH_FDATA: begin
                    emit   = 1'b1;
                    e_sym  = acc_n[7:0];
                    e_rep  = RepBits'(1);
                    e_done = (rem_q == SizeBits'(1));
                    rem_d  = rem_q - SizeBits'(1);
                    if (rem_q == SizeBits'(1)) begin
                      phase_d = PH_DONE;
                    end else begin
                      bl_d = 5'd8;
                    end
                  end
                  PH_COUNT: begin
                    ent_d   = acc_n[8:0];
                    cur_d   = '0;
                    phase_d = (acc_n[8:0] == '0) ? PH_CSIZE : PH_ELEN;
                    bl_d    = (acc_n[8:0] == '0) ? 5'(SizeBits) : 5'd5;
                  end
                  PH_ELEN: begin
                    cur_d   = '0;
                    phase_d = (acc_n[4:0] == '0) ? PH_EBYTE : PH_ECODE;
                    bl_d    = (acc_n[4:0] == '0) ? 5'd8 : acc_n[4:0];
                  end
                  PH_EBYTE: begin
                    we_b    = 1'b1;
                    wd_b    = acc_n[7:0];
                    ent_d   = ent_q - 9'd1;
                    cur_d   = '0;
                    phase_d = (ent_q == 9'd1) ? PH_CSIZE : PH_ELEN;
                    bl_d    = (ent_q == 9'd1) ? 5'(SizeBits) : 5'd5;
                  end
                  PH_CSIZE: begin
                    rem_d = acc_n;
                    if (acc_n == '0) begin
                      emit    = 1'b1;
                      e_done  = 1'b1;
                      phase_d = PH_DONE;
                    end else begin
                      // look at the root: a lone leaf repeats for the whole size
                      cur_d      = '0;
                      raddr      = '0;
                      rd_en      = 1'b1;
                      root_tst_d = 1'b1;
                      ctl_d      = C_WLEAF;
                    end
                  end
                  default: phase_d = PH_HALT;
                endcase
              end
            end
          endcase
        end
      end

      C_CNODE: begin
        if (slot != '0) begin
          cur_d   = slot;
          consume = 1'b1;
          ctl_d   = C_BIT;
          bl_d    = bl_n;
          if (bl_n == 5'd0) begin
            phase_d = PH_EBYTE;
            bl_d    = 5'd8;
            acc_d   = '0;
          end
        end else if (used_q == NodeCw'(NodeDepth)) begin
          if (can_emit) begin
            emit    = 1'b1;
            e_st    = ST_CORRUPT;
            phase_d = PH_HALT;
            consume = 1'b1;
            ctl_d   = C_BIT;
          end
        end else begin
          ctl_d = C_CINIT;
        end
      end

      C_CINIT: begin
        waddr = used_q[NodeAw-1:0];
        we_l  = 1'b1;
        we_r  = 1'b1;
        we_b  = 1'b1;
        ctl_d = C_CLINK;
      end

      C_CLINK: begin
        wd_c    = used_q[NodeAw-1:0];
        we_l    = !bit_v;
        we_r    = bit_v;
        cur_d   = used_q[NodeAw-1:0];
        used_d  = used_q + NodeCw'(1);
        consume = 1'b1;
        ctl_d   = C_BIT;
        bl_d    = bl_n;
        if (bl_n == 5'd0) begin
          phase_d = PH_EBYTE;
          bl_d    = 5'd8;
          acc_d   = '0;
        end
      end

      C_WNODE: begin
        if (slot != '0) begin
          cur_d = slot;
          raddr = slot;
          rd_en = 1'b1;
          ctl_d = C_WLEAF;
        end else if (can_emit) begin
          emit    = 1'b1;
          e_st    = ST_CORRUPT;
          phase_d = PH_HALT;
          consume = 1'b1;
          ctl_d   = C_BIT;
        end
      end

      C_WLEAF: begin
        if (can_emit) begin
          ctl_d      = C_BIT;
          root_tst_d = 1'b0;
          if (root_tst_q) begin
            if (l_rd_q == '0 && r_rd_q == '0) begin
              emit    = 1'b1;
              e_sym   = b_rd_q;
              e_rep   = RepBits'(rem_q);
              e_done  = 1'b1;
              rem_d   = '0;
              phase_d = PH_DONE;
            end else begin
              phase_d = PH_WALK;
            end
          end else begin
            consume = 1'b1;
            if (l_rd_q == '0 && r_rd_q == '0) begin
              emit   = 1'b1;
              e_sym  = b_rd_q;
              e_rep  = RepBits'(1);
              e_done = (rem_q == SizeBits'(1));
              rem_d  = rem_q - SizeBits'(1);
              cur_d  = '0;
              if (rem_q == SizeBits'(1)) begin
                phase_d = PH_DONE;
              end
            end
          end
        end
      end

      default: ctl_d = C_IDLE;
    endcase

    // a new result pushes the held one out, which is then not the last
    if (emit && pend_v_q) begin
      out_push = 1'b1;
    end

    if (consume) begin
      sh_d  = {sh_q[6:0], 1'b0};
      cnt_d = cnt_q - 4'd1;
    end
  end

  // Node store: one write port and one registered read port per array
  always_ff @(posedge clk_i) begin
    if (we_l) lm_q[waddr] <= wd_c;
    if (we_r) rm_q[waddr] <= wd_c;
    if (we_b) bm_q[waddr] <= wd_b;
    if (rd_en) begin
      l_rd_q <= lm_q[raddr];
      r_rd_q <= rm_q[raddr];
      b_rd_q <= bm_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q      <= C_INIT;
      phase_q    <= PH_SIG;
      bl_q       <= 5'd8;
      acc_q      <= '0;
      ent_q      <= '0;
      used_q     <= NodeCw'(1);
      cur_q      <= '0;
      rem_q      <= '0;
      sh_q       <= '0;
      cnt_q      <= '0;
      root_tst_q <= 1'b0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      ctl_q      <= ctl_d;
      phase_q    <= phase_d;
      bl_q       <= bl_d;
      acc_q      <= acc_d;
      ent_q      <= ent_d;
      used_q     <= used_d;
      cur_q      <= cur_d;
      rem_q      <= rem_d;
      sh_q       <= sh_d;
      cnt_q      <= cnt_d;
      root_tst_q <= root_tst_d;
      if (emit) begin
        pend_v_q <= 1'b1;
      end else if (pend_clr) begin
        pend_v_q <= 1'b0;
      end
      if (out_push) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (out_push) begin
      out_sym_q  <= pend_sym_q;
      out_rep_q  <= pend_rep_q;
      out_st_q   <= pend_st_q;
      out_done_q <= pend_done_q;
      out_last_q <= out_last;
    end
    if (emit) begin
      pend_sym_q  <= e_sym;
      pend_rep_q  <= e_rep;
      pend_st_q   <= e_st;
      pend_done_q <= e_done;
    end
  end

  assign out_valid_o    = out_v_q;
  assign symbol_o       = out_sym_q;
  assign repeat_count_o = out_rep_q;
  assign status_o       = out_st_q;
  assign stream_done_o  = out_done_q;
  assign last_o         = out_last_q;

endmodule

// ===== verif/tb_huffman_stream_decoder.sv =====
`timescale 1ns / 1ps

module tb_huffman_stream_decoder;
  import hsd_pkg::*;

  // Allow for the slowest item, eight results each held off by the longest stall,
  // a sender gap and the drain pause, then several times over.
  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned DrainPause = 60;
  localparam int unsigned MaxPerByte = 8;

  typedef struct packed {
    logic [7:0]         symbol;
    logic [RepBits-1:0] repeat_count;
    logic [1:0]         status;
    logic               stream_done;
    logic               last;
  } result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [7:0]         stream_byte_i = 8'h00;
  logic               stream_start_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [7:0]         symbol_o;
  logic [RepBits-1:0] repeat_count_o;
  logic [1:0]         status_o;
  logic               stream_done_o;
  logic               last_o;

  huffman_stream_decoder uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .stream_byte_i  (stream_byte_i),
    .stream_start_i (stream_start_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .symbol_o       (symbol_o),
    .repeat_count_o (repeat_count_o),
    .status_o       (status_o),
    .stream_done_o  (stream_done_o),
    .last_o         (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Scoreboard and run bookkeeping
  result_t     decoded_q[$];
  int unsigned error_count    = 0;
  int unsigned bytes_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned streams_sent   = 0;
  bit          quiet          = 1'b0;

  // Decoder shadow: parser, field accumulator and node store
  logic [3:0]  phase;
  int unsigned bits_left;
  logic [35:0] field_acc;
  logic [8:0]  entries_left;
  logic [4:0]  code_len;
  logic [9:0]  left_node  [NodeDepth];
  logic [9:0]  right_node [NodeDepth];
  logic [7:0]  node_byte  [NodeDepth];
  int unsigned nodes_used;
  int unsigned cur_node;
  logic [35:0] bytes_left;

  result_t     byte_results[MaxPerByte];
  int unsigned byte_result_n;

  // Stream under construction, packed most significant bit first
  logic [7:0]  stream_q[$];
  logic [7:0]  pack_reg;
  int unsigned pack_bits;

  function automatic int unsigned draw_wait();
    if (quiet) return 0;
    return $urandom_range(0, 14);
  endfunction

  function automatic int unsigned node_ix(int unsigned n);
    return (n < NodeDepth) ? n : 0;
  endfunction

  function automatic bit is_leaf(int unsigned n);
    return left_node[node_ix(n)] == '0 && right_node[node_ix(n)] == '0;
  endfunction

  task automatic add_result(logic [7:0] sym, logic [35:0] rep, logic [1:0] st, logic done);
    if (byte_result_n < MaxPerByte) begin
      byte_results[byte_result_n] = '{sym, rep[RepBits-1:0], st, done, 1'b0};
      byte_result_n++;
    end
  endtask

  task automatic halt_stream(logic [1:0] st);
    add_result(8'h00, '0, st, 1'b0);
    phase = PH_HALT;
  endtask

  task automatic open_field(logic [3:0] ph, int unsigned nbits);
    phase     = ph;
    bits_left = nbits;
    field_acc = '0;
  endtask

  task automatic clear_tree();
    for (int i = 0; i < NodeDepth; i++) begin
      left_node[i]  = '0;
      right_node[i] = '0;
      node_byte[i]  = '0;
    end
    nodes_used   = 1;
    cur_node     = 0;
    entries_left = '0;
    code_len     = '0;
    bytes_left   = '0;
    open_field(PH_SIG, 8);
  endtask

  task automatic finish_size(bit coded);
    bytes_left = field_acc & ((36'd1 << SizeBits) - 1);
    if (bytes_left == 0) begin
      add_result(8'h00, '0, ST_DATA, 1'b1);
      phase = PH_DONE;
    end else if (coded) begin
      cur_node = 0;
      if (is_leaf(0)) begin
        // Single-leaf tree: one result carries the whole size
        add_result(node_byte[0], bytes_left, ST_DATA, 1'b1);
        bytes_left = '0;
        phase      = PH_DONE;
      end else begin
        phase = PH_WALK;
      end
    end else begin
      open_field(PH_FDATA, 8);
    end
  endtask

  task automatic next_entry();
    cur_node = 0;
    if (entries_left == 0) open_field(PH_CSIZE, SizeBits);
    else open_field(PH_ELEN, 5);
  endtask

  task automatic close_field();
    logic [31:0] v;
    v = field_acc[31:0];
    case (phase)
      PH_SIG: begin
        if (v[7:0] != SigByte) halt_stream(ST_BAD_SIG);
        else open_field(PH_FLAT, 1);
      end
      PH_FLAT: begin
        if (v[0]) open_field(PH_FSIZE, SizeBits);
        else open_field(PH_COUNT, 9);
      end
      PH_FSIZE: begin
        bytes_left = field_acc;
        open_field(PH_FRES, 3);
      end
      PH_FRES: begin
        field_acc = bytes_left;
        finish_size(1'b0);
      end
      PH_FDATA: begin
        add_result(v[7:0], 36'd1, ST_DATA, bytes_left == 1);
        bytes_left--;
        if (bytes_left == 0) phase = PH_DONE;
        else open_field(PH_FDATA, 8);
      end
      PH_COUNT: begin
        entries_left = v[8:0];
        next_entry();
      end
      PH_ELEN: begin
        code_len = v[4:0];
        cur_node = 0;
        if (code_len == 0) open_field(PH_EBYTE, 8);
        else open_field(PH_ECODE, code_len);
      end
      PH_ECODE: open_field(PH_EBYTE, 8);
      PH_EBYTE: begin
        node_byte[node_ix(cur_node)] = v[7:0];
        entries_left--;
        next_entry();
      end
      PH_CSIZE: finish_size(1'b1);
      default: ;
    endcase
  endtask

  // Follow or grow the tree along one code-definition bit
  task automatic build_step(bit b);
    int unsigned n;
    logic [9:0]  child;
    n     = node_ix(cur_node);
    child = b ? right_node[n] : left_node[n];
    if (child == '0) begin
      if (nodes_used >= NodeDepth) begin
        halt_stream(ST_CORRUPT);
        return;
      end
      child = nodes_used[9:0];
      nodes_used++;
      left_node[child]  = '0;
      right_node[child] = '0;
      node_byte[child]  = '0;
      if (b) right_node[n] = child;
      else left_node[n] = child;
    end
    cur_node = node_ix(child);
  endtask

  task automatic decode_step(bit b);
    int unsigned n;
    logic [9:0]  child;
    n     = node_ix(cur_node);
    child = b ? right_node[n] : left_node[n];
    if (child == '0) begin
      halt_stream(ST_CORRUPT);
      return;
    end
    cur_node = node_ix(child);
    if (is_leaf(cur_node)) begin
      add_result(node_byte[cur_node], 36'd1, ST_DATA, bytes_left == 1);
      bytes_left--;
      cur_node = 0;
      if (bytes_left == 0) phase = PH_DONE;
    end
  endtask

  task automatic consume_bit(bit b);
    if (phase == PH_DONE || phase == PH_HALT) return;
    if (phase == PH_WALK) begin
      decode_step(b);
      return;
    end
    if (phase == PH_ECODE) begin
      build_step(b);
      if (phase == PH_HALT) return;
    end
    field_acc = {field_acc[34:0], b};
    if (bits_left > 0) bits_left--;
    if (bits_left == 0) close_field();
  endtask

  // Work out every result one accepted byte causes and queue them in order
  task automatic predict_byte(logic [7:0] data, logic start);
    byte_result_n = 0;
    if (start) clear_tree();
    for (int b = 7; b >= 0; b--) consume_bit(data[b]);
    if (byte_result_n > 0) byte_results[byte_result_n-1].last = 1'b1;
    for (int i = 0; i < byte_result_n; i++) decoded_q = {decoded_q, byte_results[i]};
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Send one item; raise valid without dropping it when there is no gap
  task automatic send_byte(logic [7:0] data, logic start);
    int unsigned gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    stream_byte_i  <= data;
    stream_start_i <= start;
    do @(posedge clk_i); while (!in_ready_o);
    predict_byte(data, start);
    bytes_sent++;
  endtask

  task automatic put_bits(logic [31:0] val, int unsigned n);
    for (int i = int'(n) - 1; i >= 0; i--) begin
      pack_reg = {pack_reg[6:0], val[i]};
      pack_bits++;
      if (pack_bits == 8) begin
        stream_q = {stream_q, pack_reg};
        pack_bits = 0;
      end
    end
  endtask

  // Pad the tail with random bits, then send the whole stream
  task automatic send_stream();
    if (pack_bits > 0) put_bits($urandom, 8 - pack_bits);
    for (int i = 0; i < stream_q.size(); i++) send_byte(stream_q[i], i == 0);
    stream_q.delete();
    streams_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    wait (decoded_q.size() == 0);
    repeat (DrainPause) @(posedge clk_i);
  endtask

  task automatic flat_header(int unsigned size);
    put_bits(SigByte, 8);
    put_bits(1, 1);
    put_bits(size, SizeBits);
    put_bits($urandom, 3);
  endtask

  task automatic coded_header(int unsigned count);
    put_bits(SigByte, 8);
    put_bits(0, 1);
    put_bits(count, 9);
  endtask

  task automatic put_entry(int unsigned len, logic [31:0] code, logic [7:0] sym);
    put_bits(len, 5);
    put_bits(code, len);
    put_bits(sym, 8);
  endtask

  task automatic test_bad_signature();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h77, 1'b0);
    send_byte(8'h76, 1'b1);
  endtask

  task automatic test_flat_passthrough();
    flat_header(3);
    put_bits(8'h00, 8);
    put_bits(8'hFF, 8);
    put_bits(8'hA5, 8);
    put_bits(8'h3C, 8);   // bytes after done must be dropped
    send_stream();
    flat_header(0);       // zero size: a status-only done
    send_stream();
  endtask

  task automatic test_single_leaf();
    coded_header(0);      // zero entries leave the root as a leaf holding 0
    put_bits(20'hFFFFF, SizeBits);
    send_stream();
    coded_header(1);      // zero-length code writes the root byte
    put_entry(0, 0, 8'h5A);
    put_bits(7, SizeBits);
    send_stream();
  endtask

  task automatic test_coded_walk();
    coded_header(5);
    put_entry(2, 2'b00, 8'h11);
    put_entry(2, 2'b01, 8'h22);
    put_entry(1, 1'b1, 8'h33);
    put_entry(2, 2'b10, 8'h44);   // extends the leaf at code 1 into a branch
    put_entry(2, 2'b01, 8'hEE);   // repeated code overwrites the byte
    put_bits(9, SizeBits);
    put_bits(18'b00_01_10_01_00_10_01_00_00, 18);
    send_stream();
  endtask

  task automatic test_missing_child();
    coded_header(1);
    put_entry(1, 1'b0, 8'h99);
    put_bits(4, SizeBits);
    put_bits(3'b001, 3);          // third bit asks for an absent right child
    put_bits(8'hFF, 8);
    send_stream();
  endtask

  task automatic test_node_overflow();
    quiet = 1'b1;
    coded_header(20);             // twenty long random codes exceed the node store
    for (int i = 0; i < 20; i++) put_entry(31, $urandom, $urandom);
    put_bits(1, SizeBits);
    send_stream();
    quiet = 1'b0;
  endtask

  task automatic test_random_streams();
    int unsigned kind, k, size, first, start_n;
    start_n = bytes_sent;
    while (bytes_sent - start_n < 30) begin
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        size = $urandom_range(1, 12);
        flat_header(size);
        for (int i = 0; i < size; i++) put_bits($urandom, 8);
      end else if (kind < 8) begin
        // Complete code of depth k, so every bit sequence decodes
        k = $urandom_range(1, 3);
        coded_header(1 << k);
        for (int i = 0; i < (1 << k); i++) put_entry(k, i, $urandom);
        size = $urandom_range(1, 20);
        put_bits(size, SizeBits);
        for (int i = 0; i < size * k; i++) put_bits($urandom, 1);
      end else begin
        for (int i = 0; i < $urandom_range(2, 6); i++) put_bits($urandom, 8);
      end
      if (kind != 9 && $urandom_range(0, 5) == 0) begin
        // Break the stream by corrupting one byte
        first = $urandom_range(0, stream_q.size() - 1);
        stream_q[first] = stream_q[first] ^ (8'd1 << $urandom_range(0, 7));
      end
      send_stream();
    end
  endtask

  // Result side: random stalls, and each accepted result checked in order
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      result_t want;
      results_seen++;
      if (decoded_q.size() == 0) begin
        $display("[%0t] result with nothing expected: symbol 0x%0h status %0d",
                 $realtime, symbol_o, status_o);
        error_count++;
      end else begin
        want = decoded_q[0];
        decoded_q.delete(0);
        if (symbol_o != want.symbol) report_mismatch("symbol", symbol_o, want.symbol);
        if (repeat_count_o != want.repeat_count)
          report_mismatch("repeat_count", repeat_count_o, want.repeat_count);
        if (status_o != want.status) report_mismatch("status", status_o, want.status);
        if (stream_done_o != want.stream_done)
          report_mismatch("stream_done", stream_done_o, want.stream_done);
        if (last_o != want.last) report_mismatch("last", last_o, want.last);
      end
      stall_left = draw_wait();
      out_ready_i <= (stall_left == 0);
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= (stall_left == 0);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Watchdog: end the run if nothing moves on either side for too long
  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("[%0t] watchdog: no progress, %0d results outstanding",
               $realtime, decoded_q.size());
      $display("** huffman_stream_decoder: FAILED **");
      $finish;
    end
  end

  initial begin
    clear_tree();
    pack_reg  = '0;
    pack_bits = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_bad_signature();
    drain();               // hold the sender until every result is back
    test_flat_passthrough();
    test_single_leaf();
    test_coded_walk();
    test_missing_child();
    test_node_overflow();
    drain();
    test_random_streams();
    drain();

    $display("Covered %0d streams in %0d bytes, %0d results checked:", streams_sent,
             bytes_sent, results_seen);
    $display("flat, coded, single-leaf, zero-size, bad signature, corrupt and overflow.");
    if (error_count == 0 && decoded_q.size() == 0) begin
      $display("** huffman_stream_decoder: PASSED **");
    end else begin
      $display("** huffman_stream_decoder: FAILED **");
    end
    $finish;
  end

endmodule
